FILE: sv/sabb_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and saturation helper for the segment versus box slab test.
package sabb_pkg;

    localparam int TF = 16;
    localparam int NW = 33 + TF;
    localparam int TW = NW + 3;
    localparam int LAT = NW + 4;

    localparam logic [TF:0] TIME_ONE = {1'b1, {TF{1'b0}}};
    localparam logic signed [TW-1:0] TIME_ONE_S = TW'(TIME_ONE);
    localparam logic signed [TW-1:0] UNBOUNDED = TW'(1) << (NW + 1);

    localparam logic [1:0] NORM_POS = 2'b01;
    localparam logic [1:0] NORM_NEG = 2'b11;
    localparam logic [1:0] NORM_NONE = 2'b00;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [TW-1:0] tn;
        logic signed [TW-1:0] tf;
        logic                 zmiss;
        logic signed [31:0]   p;
        logic signed [31:0]   d;
    } lane_t;

    typedef struct packed {
        logic [31:0] cz;
        logic [31:0] cy;
        logic [31:0] cx;
        logic [31:0] rz;
        logic [31:0] ry;
        logic [31:0] rx;
        logic [1:0]  nz;
        logic [1:0]  ny;
        logic [1:0]  nx;
        logic [TF:0] t;
        logic        hit;
    } res_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > S32_MAX)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < S32_MIN)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/sabb_lane.sv
`timescale 1ns / 1ps
// One axis lane: slab offsets and two pipelined restoring dividers for entry and exit times.
module sabb_lane (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [31:0]    center,
    input  logic [30:0]           reach,
    input  logic signed [31:0]    start,
    input  logic signed [31:0]    motion,
    output sabb_pkg::lane_t       res
);

    typedef struct packed {
        logic [sabb_pkg::NW-1:0] numn;
        logic [sabb_pkg::NW-1:0] numf;
        logic [31:0]             remn;
        logic [31:0]             remf;
        logic [sabb_pkg::NW-1:0] qn;
        logic [sabb_pkg::NW-1:0] qf;
        logic [31:0]             den;
        logic                    negn;
        logic                    negf;
        logic                    zero;
        logic                    zmiss;
        logic signed [31:0]      p;
        logic signed [31:0]      d;
    } div_t;

    div_t stage_reg [0:sabb_pkg::NW];
    div_t stage_next [0:sabb_pkg::NW];

    sabb_pkg::lane_t res_reg;
    sabb_pkg::lane_t res_next;

    logic signed [33:0] rel;
    logic signed [33:0] off;
    logic [33:0]        abs_rel;
    logic signed [32:0] md;
    logic [32:0]        absd;
    logic signed [34:0] nn;
    logic signed [34:0] nf;
    logic [34:0]        magn;
    logic [34:0]        magf;
    logic [32:0]        trn;
    logic [32:0]        trf;
    logic               bn;
    logic               bf;

    always_comb
    begin
        rel = 34'(start) - 34'(center);
        off = motion[31] ? rel : -rel;
        abs_rel = rel[33] ? 34'(-rel) : 34'(rel);
        md = 33'(motion);
        absd = md[32] ? 33'(-md) : 33'(md);
        nn = 35'(off) - $signed({4'b0, reach});
        nf = 35'(off) + $signed({4'b0, reach});
        magn = nn[34] ? 35'(-nn) : 35'(nn);
        magf = nf[34] ? 35'(-nf) : 35'(nf);

        stage_next[0].numn = {magn[32:0], {sabb_pkg::TF{1'b0}}};
        stage_next[0].numf = {magf[32:0], {sabb_pkg::TF{1'b0}}};
        stage_next[0].remn = '0;
        stage_next[0].remf = '0;
        stage_next[0].qn = '0;
        stage_next[0].qf = '0;
        stage_next[0].den = absd[31:0];
        stage_next[0].negn = nn[34];
        stage_next[0].negf = nf[34];
        stage_next[0].zero = (motion == 32'sd0);
        stage_next[0].zmiss = (motion == 32'sd0) && (abs_rel >= {3'b0, reach});
        stage_next[0].p = start;
        stage_next[0].d = motion;

        for (int k = 0; k < sabb_pkg::NW; k++)
        begin
            stage_next[k+1] = stage_reg[k];
            trn = {stage_reg[k].remn, stage_reg[k].numn[sabb_pkg::NW-1]};
            trf = {stage_reg[k].remf, stage_reg[k].numf[sabb_pkg::NW-1]};
            bn = (trn >= {1'b0, stage_reg[k].den});
            bf = (trf >= {1'b0, stage_reg[k].den});
            stage_next[k+1].remn = bn ? 32'(trn - {1'b0, stage_reg[k].den}) : trn[31:0];
            stage_next[k+1].remf = bf ? 32'(trf - {1'b0, stage_reg[k].den}) : trf[31:0];
            stage_next[k+1].numn = stage_reg[k].numn << 1;
            stage_next[k+1].numf = stage_reg[k].numf << 1;
            stage_next[k+1].qn = {stage_reg[k].qn[sabb_pkg::NW-2:0], bn};
            stage_next[k+1].qf = {stage_reg[k].qf[sabb_pkg::NW-2:0], bf};
        end
    end

    always_comb
    begin
        res_next.p = stage_reg[sabb_pkg::NW].p;
        res_next.d = stage_reg[sabb_pkg::NW].d;
        res_next.zmiss = stage_reg[sabb_pkg::NW].zmiss;
        if (stage_reg[sabb_pkg::NW].zero)
        begin
            res_next.tn = -sabb_pkg::UNBOUNDED;
            res_next.tf = sabb_pkg::UNBOUNDED;
        end
        else
        begin
            if (stage_reg[sabb_pkg::NW].negn)
            begin
                res_next.tn = -$signed(sabb_pkg::TW'(stage_reg[sabb_pkg::NW].qn))
                    - sabb_pkg::TW'(stage_reg[sabb_pkg::NW].remn != 32'd0);
            end
            else
            begin
                res_next.tn = $signed(sabb_pkg::TW'(stage_reg[sabb_pkg::NW].qn));
            end
            if (stage_reg[sabb_pkg::NW].negf)
            begin
                res_next.tf = -$signed(sabb_pkg::TW'(stage_reg[sabb_pkg::NW].qf))
                    - sabb_pkg::TW'(stage_reg[sabb_pkg::NW].remf != 32'd0);
            end
            else
            begin
                res_next.tf = $signed(sabb_pkg::TW'(stage_reg[sabb_pkg::NW].qf));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= sabb_pkg::NW; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: sv/sabb_merge.sv
`timescale 1ns / 1ps
// Merge of the three lanes: slab overlap, entry time, normal, then rest and contact products.
module sabb_merge (
    input  logic                  clk,
    input  logic                  en,
    input  sabb_pkg::lane_t       lane [3],
    output sabb_pkg::res_t        res
);

    logic signed [sabb_pkg::TW-1:0] tnear;
    logic signed [sabb_pkg::TW-1:0] tfar;
    logic                           crossed;
    logic                           zm;
    logic                           miss;
    logic [1:0]                     axis;
    logic [sabb_pkg::TF:0]          t_m;
    logic [1:0]                     nrm [3];

    logic                  hit_m_reg;
    logic [sabb_pkg::TF:0] t_m_reg;
    logic [1:0]            nrm_m_reg [3];
    logic signed [31:0]    p_m_reg [3];
    logic signed [31:0]    d_m_reg [3];

    logic [sabb_pkg::TF:0]                 omt;
    logic signed [32:0]                    nd [3];
    logic signed [33+sabb_pkg::TF+1:0]     pr [3];
    logic signed [32+sabb_pkg::TF+1:0]     pc [3];

    logic                                  hit_p_reg;
    logic [sabb_pkg::TF:0]                 t_p_reg;
    logic [1:0]                            nrm_p_reg [3];
    logic signed [31:0]                    p_p_reg [3];
    logic signed [33+sabb_pkg::TF+1:0]     pr_reg [3];
    logic signed [32+sabb_pkg::TF+1:0]     pc_reg [3];

    logic [31:0] rest [3];
    logic [31:0] cont [3];

    always_comb
    begin
        tnear = lane[0].tn;
        tfar = lane[0].tf;
        for (int i = 1; i < 3; i++)
        begin
            if (lane[i].tn > tnear)
            begin
                tnear = lane[i].tn;
            end
            if (lane[i].tf < tfar)
            begin
                tfar = lane[i].tf;
            end
        end
        crossed = 1'b0;
        zm = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            zm = zm | lane[i].zmiss;
            for (int j = 0; j < 3; j++)
            begin
                if (i != j && lane[i].tn > lane[j].tf)
                begin
                    crossed = 1'b1;
                end
            end
        end
        miss = zm || crossed || (tnear >= sabb_pkg::TIME_ONE_S) || (tfar <= 0);
        t_m = tnear[sabb_pkg::TW-1] ? '0 : tnear[sabb_pkg::TF:0];
        if (lane[0].tn > lane[1].tn && lane[0].tn > lane[2].tn)
        begin
            axis = 2'd0;
        end
        else if (lane[1].tn > lane[0].tn && lane[1].tn > lane[2].tn)
        begin
            axis = 2'd1;
        end
        else
        begin
            axis = 2'd2;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (!miss && axis == 2'(i))
            begin
                nrm[i] = lane[i].d[31] ? sabb_pkg::NORM_POS : sabb_pkg::NORM_NEG;
            end
            else
            begin
                nrm[i] = sabb_pkg::NORM_NONE;
            end
        end
    end

    always_comb
    begin
        omt = sabb_pkg::TIME_ONE - t_m_reg;
        for (int i = 0; i < 3; i++)
        begin
            nd[i] = -(33'(d_m_reg[i]));
            pr[i] = nd[i] * $signed({1'b0, omt});
            pc[i] = d_m_reg[i] * $signed({1'b0, t_m_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_m_reg <= !miss;
            t_m_reg <= miss ? '0 : t_m;
            for (int i = 0; i < 3; i++)
            begin
                nrm_m_reg[i] <= nrm[i];
                p_m_reg[i] <= lane[i].p;
                d_m_reg[i] <= lane[i].d;
            end
            hit_p_reg <= hit_m_reg;
            t_p_reg <= t_m_reg;
            for (int i = 0; i < 3; i++)
            begin
                nrm_p_reg[i] <= nrm_m_reg[i];
                p_p_reg[i] <= p_m_reg[i];
                pr_reg[i] <= pr[i];
                pc_reg[i] <= pc[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (hit_p_reg)
            begin
                rest[i] = sabb_pkg::sat32(64'(pr_reg[i] >>> sabb_pkg::TF));
                cont[i] = sabb_pkg::sat32(64'(p_p_reg[i]) + 64'(pc_reg[i] >>> sabb_pkg::TF));
            end
            else
            begin
                rest[i] = '0;
                cont[i] = '0;
            end
        end
        res.hit = hit_p_reg;
        res.t = t_p_reg;
        res.nx = nrm_p_reg[0];
        res.ny = nrm_p_reg[1];
        res.nz = nrm_p_reg[2];
        res.rx = rest[0];
        res.ry = rest[1];
        res.rz = rest[2];
        res.cx = cont[0];
        res.cy = cont[1];
        res.cz = cont[2];
    end

endmodule

FILE: sv/segment_aabb_slab_intersect.sv
`timescale 1ns / 1ps
// Each axis lane runs 49 restoring divider steps, one quotient bit a cycle while the pipeline
// is enabled. Throughput is one word per cycle unless the skid entry is full; a two-entry
// output buffer keeps the pipeline moving while one result waits. rst_n clears only the
// valid bits, asynchronously; no clearing pass.
module segment_aabb_slab_intersect (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cx, cy, cz (32 each), rx, ry, rz (31 each), sx, sy, sz, mx, my, mz (32 each), zero pad.
    input  logic [383:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // entry_time (17), normal x, y, z (2 each), rest x, y, z, contact x, y, z (32 each), pad.
    output logic [215:0] m_tdata,
    // hit.
    output logic         m_tuser
);

    logic [sabb_pkg::LAT-1:0] v_reg;
    logic [sabb_pkg::LAT-1:0] v_next;
    logic                     en;
    logic                     pv;

    sabb_pkg::lane_t lane_res [3];
    sabb_pkg::res_t  pipe_res;
    sabb_pkg::res_t  out_reg;
    sabb_pkg::res_t  skid_reg;
    logic            out_v_reg;
    logic            skid_v_reg;

    assign en = !skid_v_reg;
    assign s_tready = en;
    assign pv = v_reg[sabb_pkg::LAT-1];
    assign v_next = en ? {v_reg[sabb_pkg::LAT-2:0], s_tvalid} : v_reg;

    sabb_lane u_lane_x (
        .clk    (clk),
        .en     (en),
        .center ($signed(s_tdata[31:0])),
        .reach  (s_tdata[126:96]),
        .start  ($signed(s_tdata[220:189])),
        .motion ($signed(s_tdata[316:285])),
        .res    (lane_res[0])
    );

    sabb_lane u_lane_y (
        .clk    (clk),
        .en     (en),
        .center ($signed(s_tdata[63:32])),
        .reach  (s_tdata[157:127]),
        .start  ($signed(s_tdata[252:221])),
        .motion ($signed(s_tdata[348:317])),
        .res    (lane_res[1])
    );

    sabb_lane u_lane_z (
        .clk    (clk),
        .en     (en),
        .center ($signed(s_tdata[95:64])),
        .reach  (s_tdata[188:158]),
        .start  ($signed(s_tdata[284:253])),
        .motion ($signed(s_tdata[380:349])),
        .res    (lane_res[2])
    );

    sabb_merge u_merge (
        .clk  (clk),
        .en   (en),
        .lane (lane_res),
        .res  (pipe_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            out_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
            if (!out_v_reg || m_tready)
            begin
                if (skid_v_reg)
                begin
                    out_v_reg <= 1'b1;
                    skid_v_reg <= 1'b0;
                end
                else
                begin
                    out_v_reg <= pv;
                end
            end
            else if (pv && en)
            begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || m_tready)
        begin
            out_reg <= skid_v_reg ? skid_reg : pipe_res;
        end
        else if (pv && en)
        begin
            skid_reg <= pipe_res;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser = out_reg.hit;
    assign m_tdata = {1'b0, out_reg.cz, out_reg.cy, out_reg.cx, out_reg.rz, out_reg.ry,
                      out_reg.rx, out_reg.nz, out_reg.ny, out_reg.nx, out_reg.t};

endmodule
